@@ design/abkf_pkg.sv @@
`timescale 1ns / 1ps
package abkf_pkg;

   localparam int AngW   = 32;
   localparam int CovW   = 48;
   localparam int NoiseW = 24;
   localparam int WideW  = 64;
   localparam int ProdW  = 2 * CovW;
   localparam int CsrIdxW = 2;

   // bit-serial step counts
   localparam int MulSteps = CovW;
   localparam int DivSteps = CovW + 40;
   // last divider step, counted from zero, on which a set quotient bit overflows Q8.40
   localparam int DivOverLast = DivSteps - 1 - (CovW - 1);
   // cap for product magnitudes: any value this large saturates downstream
   localparam int MulCapBit = CovW + 1;

   localparam logic [CsrIdxW-1:0] CSR_ANGLE_NOISE   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_BIAS_NOISE    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MEASURE_NOISE = 2'd2;

   localparam logic [NoiseW-1:0] ANGLE_NOISE_RST   = 24'd16777;
   localparam logic [NoiseW-1:0] BIAS_NOISE_RST    = 24'd50332;
   localparam logic [NoiseW-1:0] MEASURE_NOISE_RST = 24'd503316;

   localparam logic signed [WideW-1:0] Max32 = 64'sd2147483647;
   localparam logic signed [WideW-1:0] Min32 = -64'sd2147483648;
   localparam logic signed [WideW-1:0] Max48 = 64'sd140737488355327;
   localparam logic signed [WideW-1:0] Min48 = -64'sd140737488355328;

   typedef enum logic [1:0] {
      SH_8,
      SH_24,
      SH_40
   } shift_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RATE,
      ST_ANG,
      ST_P11,
      ST_C01,
      ST_INA,
      ST_INB,
      ST_C00,
      ST_C11,
      ST_S,
      ST_K0,
      ST_K1,
      ST_Y,
      ST_ANG2,
      ST_BIAS,
      ST_C10B,
      ST_C11B,
      ST_C00B,
      ST_C01B,
      ST_OUT
   } step_type;

   typedef struct packed {
      logic                     start;
      logic signed [CovW-1:0]   a;
      logic signed [CovW-1:0]   b;
      shift_type                sh;
   } mul_req_type;

   typedef struct packed {
      logic                     start;
      logic signed [CovW-1:0]   num;
      logic signed [CovW-1:0]   den;
   } div_req_type;

   function automatic logic [CovW-1:0] mag48(input logic signed [CovW-1:0] v);
      mag48 = v[CovW-1] ? CovW'(-v) : CovW'(v);
   endfunction

   function automatic logic signed [AngW-1:0] sat32(input logic signed [WideW-1:0] v);
      if (v > Max32) begin
         sat32 = Max32[AngW-1:0];
      end else if (v < Min32) begin
         sat32 = Min32[AngW-1:0];
      end else begin
         sat32 = v[AngW-1:0];
      end
   endfunction

   function automatic logic signed [CovW-1:0] sat48(input logic signed [WideW-1:0] v);
      if (v > Max48) begin
         sat48 = Max48[CovW-1:0];
      end else if (v < Min48) begin
         sat48 = Min48[CovW-1:0];
      end else begin
         sat48 = v[CovW-1:0];
      end
   endfunction

endpackage

@@ design/abkf_if.sv @@
`timescale 1ns / 1ps
interface abkf_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   req_type;
   logic signed [abkf_pkg::AngW-1:0]       measured_angle;
   logic signed [abkf_pkg::AngW-1:0]       gyro_rate;
   logic [abkf_pkg::NoiseW-1:0]            time_step;

   modport source(output valid, req_type, measured_angle, gyro_rate, time_step, input ready);
   modport sink(input valid, req_type, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface abkf_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [abkf_pkg::AngW-1:0]       filtered_angle;
   logic signed [abkf_pkg::AngW-1:0]       unbiased_rate;

   modport source(output valid, filtered_angle, unbiased_rate, input ready);
   modport sink(input valid, filtered_angle, unbiased_rate, output ready);
endinterface

@@ design/angle_bias_kalman_filter_unit.sv @@
`timescale 1ns / 1ps
// Two-state angle and gyro-bias Kalman filter in fixed point (angle and rate
// Q16.16, time step and noise Q0.24, covariance and gain Q8.40). A load
// transaction sets the angle estimate. An update transaction runs a sequencer
// over ten multiplies on a bit-serial shift-add multiplier, two gain divisions
// on a bit-serial restoring divider and its add and subtract steps. Either
// transaction offers its result from the output state, which holds while a full
// result register waits for the sink to take the previous result. One
// transaction is in flight at a time; the result register holds a finished
// result while the next transaction is accepted. The user must write the noise
// registers through the csr port only while the block is idle; the block itself
// does not enforce this.
module angle_bias_kalman_filter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   abkf_req_if.sink                             req_chan,
   abkf_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [abkf_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [abkf_pkg::NoiseW-1:0]          csr_wdata
);

   localparam int CovW = abkf_pkg::CovW;
   localparam int AngW = abkf_pkg::AngW;
   localparam int WideW = abkf_pkg::WideW;

   abkf_pkg::step_type              step_ff, step_in;
   logic                            wait_ff, wait_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [AngW-1:0]          rsp_angle_ff, rsp_angle_in;
   logic signed [AngW-1:0]          rsp_rate_ff, rsp_rate_in;

   logic [abkf_pkg::NoiseW-1:0]     qa_noise_ff, qb_noise_ff, rm_noise_ff;

   logic signed [AngW-1:0]          angle_ff, angle_in;
   logic signed [AngW-1:0]          bias_ff, bias_in;
   logic signed [CovW-1:0]          c00_ff, c00_in;
   logic signed [CovW-1:0]          c01_ff, c01_in;
   logic signed [CovW-1:0]          c10_ff, c10_in;
   logic signed [CovW-1:0]          c11_ff, c11_in;

   logic signed [AngW-1:0]          meas_ff, meas_in;
   logic signed [AngW-1:0]          gyro_ff, gyro_in;
   logic [abkf_pkg::NoiseW-1:0]     dt_ff, dt_in;
   logic signed [AngW-1:0]          rate_ff, rate_in;
   logic signed [CovW-1:0]          tmp_ff, tmp_in;
   logic signed [WideW-1:0]         acc_ff, acc_in;
   logic signed [CovW-1:0]          k0_ff, k0_in;
   logic signed [CovW-1:0]          k1_ff, k1_in;

   abkf_pkg::mul_req_type           mul_req;
   abkf_pkg::div_req_type           div_req;
   logic                            mul_done, div_done;
   logic signed [WideW-1:0]         mul_res;
   logic signed [CovW-1:0]          div_quot;
   logic                            unit_step, fin;
   logic signed [CovW-1:0]          dt48;
   logic signed [WideW-1:0]         qa_wide, rm_wide;

   abkf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .done   (mul_done),
      .result (mul_res)
   );

   abkf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign dt48    = CovW'({1'b0, dt_ff});
   assign qa_wide = WideW'({qa_noise_ff, 16'd0});
   assign rm_wide = WideW'({rm_noise_ff, 16'd0});
   assign fin     = wait_ff & (mul_done | div_done);

   // sequence the load and the update: one arithmetic step per state
   always_comb begin
      step_in      = step_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_rate_in  = rsp_rate_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      c00_in       = c00_ff;
      c01_in       = c01_ff;
      c10_in       = c10_ff;
      c11_in       = c11_ff;
      meas_in      = meas_ff;
      gyro_in      = gyro_ff;
      dt_in        = dt_ff;
      rate_in      = rate_ff;
      tmp_in       = tmp_ff;
      acc_in       = acc_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      mul_req      = '0;
      mul_req.sh   = abkf_pkg::SH_40;
      div_req      = '0;
      unit_step    = 1'b0;

      // drop the result once the sink takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (step_ff)
         abkf_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               meas_in = req_chan.measured_angle;
               gyro_in = req_chan.gyro_rate;
               dt_in   = req_chan.time_step;
               if (req_chan.req_type) begin
                  angle_in = req_chan.measured_angle;
                  rate_in  = '0;
                  step_in  = abkf_pkg::ST_OUT;
               end else begin
                  step_in = abkf_pkg::ST_RATE;
               end
            end
         end
         abkf_pkg::ST_RATE: begin
            rate_in = abkf_pkg::sat32(WideW'(gyro_ff) - WideW'(bias_ff));
            step_in = abkf_pkg::ST_ANG;
         end
         abkf_pkg::ST_ANG: begin
            unit_step  = 1'b1;
            mul_req.a  = dt48;
            mul_req.b  = CovW'(rate_ff);
            mul_req.sh = abkf_pkg::SH_24;
            if (fin) begin
               angle_in = abkf_pkg::sat32(WideW'(angle_ff) + mul_res);
               step_in  = abkf_pkg::ST_P11;
            end
         end
         abkf_pkg::ST_P11: begin
            unit_step  = 1'b1;
            mul_req.a  = dt48;
            mul_req.b  = c11_ff;
            mul_req.sh = abkf_pkg::SH_24;
            if (fin) begin
               tmp_in  = abkf_pkg::sat48(mul_res);
               step_in = abkf_pkg::ST_C01;
            end
         end
         abkf_pkg::ST_C01: begin
            c01_in  = abkf_pkg::sat48(WideW'(c01_ff) - WideW'(tmp_ff));
            c10_in  = abkf_pkg::sat48(WideW'(c10_ff) - WideW'(tmp_ff));
            step_in = abkf_pkg::ST_INA;
         end
         abkf_pkg::ST_INA: begin
            acc_in  = WideW'(tmp_ff) - WideW'(c01_ff);
            step_in = abkf_pkg::ST_INB;
         end
         abkf_pkg::ST_INB: begin
            tmp_in  = abkf_pkg::sat48(acc_ff - WideW'(c10_ff) + qa_wide);
            step_in = abkf_pkg::ST_C00;
         end
         abkf_pkg::ST_C00: begin
            unit_step  = 1'b1;
            mul_req.a  = dt48;
            mul_req.b  = tmp_ff;
            mul_req.sh = abkf_pkg::SH_24;
            if (fin) begin
               c00_in  = abkf_pkg::sat48(WideW'(c00_ff) + mul_res);
               step_in = abkf_pkg::ST_C11;
            end
         end
         abkf_pkg::ST_C11: begin
            unit_step  = 1'b1;
            mul_req.a  = CovW'({1'b0, qb_noise_ff});
            mul_req.b  = dt48;
            mul_req.sh = abkf_pkg::SH_8;
            if (fin) begin
               c11_in  = abkf_pkg::sat48(WideW'(c11_ff) + mul_res);
               step_in = abkf_pkg::ST_S;
            end
         end
         abkf_pkg::ST_S: begin
            tmp_in  = abkf_pkg::sat48(WideW'(c00_ff) + rm_wide);
            step_in = abkf_pkg::ST_K0;
         end
         abkf_pkg::ST_K0: begin
            unit_step   = 1'b1;
            div_req.num = c00_ff;
            div_req.den = tmp_ff;
            if (fin) begin
               k0_in   = div_quot;
               step_in = abkf_pkg::ST_K1;
            end
         end
         abkf_pkg::ST_K1: begin
            unit_step   = 1'b1;
            div_req.num = c10_ff;
            div_req.den = tmp_ff;
            if (fin) begin
               k1_in   = div_quot;
               step_in = abkf_pkg::ST_Y;
            end
         end
         abkf_pkg::ST_Y: begin
            tmp_in  = CovW'(abkf_pkg::sat32(WideW'(meas_ff) - WideW'(angle_ff)));
            step_in = abkf_pkg::ST_ANG2;
         end
         abkf_pkg::ST_ANG2: begin
            unit_step = 1'b1;
            mul_req.a = k0_ff;
            mul_req.b = tmp_ff;
            if (fin) begin
               angle_in = abkf_pkg::sat32(WideW'(angle_ff) + mul_res);
               step_in  = abkf_pkg::ST_BIAS;
            end
         end
         abkf_pkg::ST_BIAS: begin
            unit_step = 1'b1;
            mul_req.a = k1_ff;
            mul_req.b = tmp_ff;
            if (fin) begin
               bias_in = abkf_pkg::sat32(WideW'(bias_ff) + mul_res);
               step_in = abkf_pkg::ST_C10B;
            end
         end
         // correct cov_10 and cov_11 first, while cov_00 and cov_01 are unchanged
         abkf_pkg::ST_C10B: begin
            unit_step = 1'b1;
            mul_req.a = k1_ff;
            mul_req.b = c00_ff;
            if (fin) begin
               c10_in  = abkf_pkg::sat48(WideW'(c10_ff) - mul_res);
               step_in = abkf_pkg::ST_C11B;
            end
         end
         abkf_pkg::ST_C11B: begin
            unit_step = 1'b1;
            mul_req.a = k1_ff;
            mul_req.b = c01_ff;
            if (fin) begin
               c11_in  = abkf_pkg::sat48(WideW'(c11_ff) - mul_res);
               step_in = abkf_pkg::ST_C00B;
            end
         end
         abkf_pkg::ST_C00B: begin
            unit_step = 1'b1;
            mul_req.a = k0_ff;
            mul_req.b = c00_ff;
            if (fin) begin
               c00_in  = abkf_pkg::sat48(WideW'(c00_ff) - mul_res);
               step_in = abkf_pkg::ST_C01B;
            end
         end
         abkf_pkg::ST_C01B: begin
            unit_step = 1'b1;
            mul_req.a = k0_ff;
            mul_req.b = c01_ff;
            if (fin) begin
               c01_in  = abkf_pkg::sat48(WideW'(c01_ff) - mul_res);
               step_in = abkf_pkg::ST_OUT;
            end
         end
         abkf_pkg::ST_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = angle_ff;
               rsp_rate_in  = rate_ff;
               step_in      = abkf_pkg::ST_IDLE;
            end
         end
         default: begin
            step_in = abkf_pkg::ST_IDLE;
         end
      endcase

      // launch the multiplier or the divider on entry, release it on completion
      if (unit_step) begin
         if (!wait_ff) begin
            wait_in = 1'b1;
            if (step_ff == abkf_pkg::ST_K0 || step_ff == abkf_pkg::ST_K1) begin
               div_req.start = 1'b1;
            end else begin
               mul_req.start = 1'b1;
            end
         end else if (fin) begin
            wait_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= abkf_pkg::ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         bias_ff      <= '0;
         c00_ff       <= '0;
         c01_ff       <= '0;
         c10_ff       <= '0;
         c11_ff       <= '0;
      end else begin
         step_ff      <= step_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         c00_ff       <= c00_in;
         c01_ff       <= c01_in;
         c10_ff       <= c10_in;
         c11_ff       <= c11_in;
      end
      rsp_angle_ff <= rsp_angle_in;
      rsp_rate_ff  <= rsp_rate_in;
      meas_ff      <= meas_in;
      gyro_ff      <= gyro_in;
      dt_ff        <= dt_in;
      rate_ff      <= rate_in;
      tmp_ff       <= tmp_in;
      acc_ff       <= acc_in;
      k0_ff        <= k0_in;
      k1_ff        <= k1_in;
   end

   // noise registers; writes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         qa_noise_ff <= abkf_pkg::ANGLE_NOISE_RST;
         qb_noise_ff <= abkf_pkg::BIAS_NOISE_RST;
         rm_noise_ff <= abkf_pkg::MEASURE_NOISE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            abkf_pkg::CSR_ANGLE_NOISE:   qa_noise_ff <= csr_wdata;
            abkf_pkg::CSR_BIAS_NOISE:    qb_noise_ff <= csr_wdata;
            abkf_pkg::CSR_MEASURE_NOISE: rm_noise_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_chan.ready          = (step_ff == abkf_pkg::ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_angle = rsp_angle_ff;
   assign rsp_chan.unbiased_rate  = rsp_rate_ff;

endmodule

@@ design/abkf_mul.sv @@
`timescale 1ns / 1ps
module abkf_mul (
   input  logic                                     clock,
   input  logic                                     reset,
   input  abkf_pkg::mul_req_type                    req,
   output logic                                     done,
   output logic signed [abkf_pkg::WideW-1:0]        result
);

   localparam int CntW = $clog2(abkf_pkg::MulSteps);
   localparam logic [CntW-1:0] CntLast = CntW'(abkf_pkg::MulSteps - 1);
   localparam logic [abkf_pkg::ProdW-1:0] ProdOne = abkf_pkg::ProdW'(1);
   localparam logic [abkf_pkg::ProdW-1:0] MulCap  = ProdOne << abkf_pkg::MulCapBit;

   logic                            busy_ff, busy_in;
   logic                            fin_ff, fin_in;
   logic                            done_ff, done_in;
   logic [CntW-1:0]                 cnt_ff, cnt_in;
   logic [abkf_pkg::CovW-1:0]       ua_ff, ua_in;
   logic [abkf_pkg::CovW-1:0]       ub_ff, ub_in;
   logic [abkf_pkg::CovW-1:0]       hi_ff, hi_in;
   logic [abkf_pkg::CovW-1:0]       lo_ff, lo_in;
   logic                            neg_ff, neg_in;
   abkf_pkg::shift_type             sh_ff, sh_in;
   logic signed [abkf_pkg::WideW-1:0] res_ff, res_in;

   logic [abkf_pkg::CovW:0]         sum;
   logic [abkf_pkg::ProdW-1:0]      prod;
   logic [abkf_pkg::ProdW-1:0]      rnd;
   logic [abkf_pkg::ProdW-1:0]      capped;
   logic [abkf_pkg::WideW-1:0]      magx;

   // one partial product per cycle, accumulator shifts right
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      neg_in  = neg_ff;
      sh_in   = sh_ff;
      res_in  = res_ff;

      sum = {1'b0, hi_ff} + (ub_ff[0] ? {1'b0, ua_ff} : '0);

      prod = {hi_ff, lo_ff};
      case (sh_ff)
         abkf_pkg::SH_8:  rnd = (prod + (ProdOne << 7)) >> 8;
         abkf_pkg::SH_24: rnd = (prod + (ProdOne << 23)) >> 24;
         abkf_pkg::SH_40: rnd = (prod + (ProdOne << 39)) >> 40;
         default:         rnd = (prod + (ProdOne << 39)) >> 40;
      endcase
      capped = (rnd > MulCap) ? MulCap : rnd;
      magx   = abkf_pkg::WideW'(capped[abkf_pkg::MulCapBit:0]);

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ua_in   = abkf_pkg::mag48(req.a);
         ub_in   = abkf_pkg::mag48(req.b);
         hi_in   = '0;
         lo_in   = '0;
         neg_in  = req.a[abkf_pkg::CovW-1] ^ req.b[abkf_pkg::CovW-1];
         sh_in   = req.sh;
      end else if (busy_ff) begin
         hi_in  = sum[abkf_pkg::CovW:1];
         lo_in  = {sum[0], lo_ff[abkf_pkg::CovW-1:1]};
         ub_in  = ub_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntLast) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // round, cap and apply the sign
         res_in  = neg_ff ? -$signed(magx) : $signed(magx);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      neg_ff <= neg_in;
      sh_ff  <= sh_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

@@ design/abkf_div.sv @@
`timescale 1ns / 1ps
module abkf_div (
   input  logic                                     clock,
   input  logic                                     reset,
   input  abkf_pkg::div_req_type                    req,
   output logic                                     done,
   output logic signed [abkf_pkg::CovW-1:0]         quot
);

   localparam int CntW = $clog2(abkf_pkg::DivSteps);
   localparam int QW   = abkf_pkg::CovW - 1;
   localparam logic [CntW-1:0] CntLast = CntW'(abkf_pkg::DivSteps - 1);
   localparam logic [CntW-1:0] OverLast = CntW'(abkf_pkg::DivOverLast);

   logic                            busy_ff, busy_in;
   logic                            fin_ff, fin_in;
   logic                            done_ff, done_in;
   logic [CntW-1:0]                 cnt_ff, cnt_in;
   logic [abkf_pkg::CovW-1:0]       nsh_ff, nsh_in;
   logic [abkf_pkg::CovW-1:0]       d_ff, d_in;
   logic [abkf_pkg::CovW-1:0]       r_ff, r_in;
   logic [QW-1:0]                   q_ff, q_in;
   logic                            over_ff, over_in;
   logic                            neg_ff, neg_in;
   logic                            zero_ff, zero_in;
   logic signed [abkf_pkg::CovW-1:0] quot_ff, quot_in;

   logic [abkf_pkg::CovW-1:0]       rs;
   logic                            ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nsh_in  = nsh_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      over_in = over_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      quot_in = quot_ff;

      rs = {r_ff[abkf_pkg::CovW-2:0], nsh_ff[abkf_pkg::CovW-1]};
      ge = (rs >= d_ff);

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         nsh_in  = abkf_pkg::mag48(req.num);
         d_in    = abkf_pkg::mag48(req.den);
         r_in    = '0;
         q_in    = '0;
         over_in = 1'b0;
         neg_in  = req.num[abkf_pkg::CovW-1] ^ req.den[abkf_pkg::CovW-1];
         zero_in = (req.den == '0);
      end else if (busy_ff) begin
         nsh_in = nsh_ff << 1;
         r_in   = ge ? (rs - d_ff) : rs;
         q_in   = {q_ff[QW-2:0], ge};
         if (ge && (cnt_ff <= OverLast)) begin
            over_in = 1'b1;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntLast) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // force zero gain, saturate or apply the sign
         if (zero_ff) begin
            quot_in = '0;
         end else if (over_ff) begin
            quot_in = neg_ff ? abkf_pkg::Min48[abkf_pkg::CovW-1:0]
                             : abkf_pkg::Max48[abkf_pkg::CovW-1:0];
         end else begin
            quot_in = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      nsh_ff  <= nsh_in;
      d_ff    <= d_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
      over_ff <= over_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ design/abkf_checker.sv @@
`timescale 1ns / 1ps
module abkf_props (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a transaction never produces its result in the next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

   // one transaction at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");

endmodule

bind angle_bias_kalman_filter_unit abkf_props u_abkf_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
